/* rtl/command_frame_builder_crc16_top_defines.svh */
// assertion macros shared by the frame builder rtl
// no dependencies; included by the files that check their own logic
`ifndef COMMAND_FRAME_BUILDER_CRC16_TOP_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CRC16_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfb assertion failed");
// next-cycle implication
`define CFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfb assertion failed");
`else
`define CFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/cfb_pkg.sv */
// shared types, constants and the crc byte update for the frame builder
// no dependencies
`default_nettype none

package cfb_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int LEN_W  = 11;
    localparam int TOT_W  = 16;
    localparam int STEP_W = 4;

    // input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // configuration register indexes
    localparam logic REG_DEST = 1'b0;
    localparam logic REG_SRC  = 1'b1;

    localparam logic [31:0] DEST_RESET = 32'h0100_0110;
    localparam logic [31:0] SRC_RESET  = 32'h0000_0001;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [TOT_W-1:0] LEN_OFFSET = 16'd6;
    localparam logic [TOT_W-1:0] LEN_MIN    = 16'd8;

    // header byte positions within a start command
    localparam logic [STEP_W-1:0] HDR_DEST0 = 4'd0;
    localparam logic [STEP_W-1:0] HDR_DEST1 = 4'd1;
    localparam logic [STEP_W-1:0] HDR_DEST2 = 4'd2;
    localparam logic [STEP_W-1:0] HDR_DEST3 = 4'd3;
    localparam logic [STEP_W-1:0] HDR_SRC0  = 4'd4;
    localparam logic [STEP_W-1:0] HDR_SRC1  = 4'd5;
    localparam logic [STEP_W-1:0] HDR_SRC2  = 4'd6;
    localparam logic [STEP_W-1:0] HDR_SRC3  = 4'd7;
    localparam logic [STEP_W-1:0] HDR_LENLO = 4'd8;
    localparam logic [STEP_W-1:0] HDR_LENHI = 4'd9;
    localparam logic [STEP_W-1:0] HDR_OP    = 4'd10;
    localparam logic [STEP_W-1:0] HDR_OBJ0  = 4'd11;
    localparam logic [STEP_W-1:0] HDR_OBJ1  = 4'd12;
    localparam logic [STEP_W-1:0] HDR_OBJ2  = 4'd13;
    localparam logic [STEP_W-1:0] DATA_POS  = 4'd0;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_kind_t;

    // one classified command handed from front to back
    typedef struct packed {
        cmd_kind_t        kind;
        logic             crc_after;
        logic [7:0]       data;
        logic [7:0]       op;
        logic [23:0]      obj;
        logic [TOT_W-1:0] total;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // one byte through the reflected crc-16 register
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/cfb_front.sv */
// front end: accepts input beats, tracks the open frame, queues commands
// depends on cfb_pkg
`default_nettype none

module cfb_front
    import cfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             action,
    input  wire logic [7:0]       operation,
    input  wire logic [23:0]      object_id,
    input  wire logic [LEN_W-1:0] payload_length,
    input  wire logic [7:0]       payload_byte,
    input  wire q_status_t        q_status,
    output logic                  push,
    output cmd_t                  push_cmd
);

    localparam logic [16:0] MAX_W = 17'(MAX_PAYLOAD);

    logic             open_reg, open_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [LEN_W-1:0] plen_c;
    logic [TOT_W-1:0] total_c;
    logic             accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // clamp length and form the length field
    always_comb
    begin
        if ({6'b0, payload_length} > MAX_W)
            plen_c = MAX_W[LEN_W-1:0];
        else
            plen_c = payload_length;
        total_c = TOT_W'(plen_c) + LEN_OFFSET;
        if (total_c < LEN_MIN)
            total_c = LEN_MIN;
    end

    // classify the beat
    always_comb
    begin
        open_next   = open_reg;
        remain_next = remain_reg;
        push        = 1'b0;
        push_cmd    = '0;
        push_cmd.op    = operation;
        push_cmd.obj   = object_id;
        push_cmd.total = total_c;
        push_cmd.data  = payload_byte;
        if (accept)
        begin
            if (action == ACT_START)
            begin
                push               = 1'b1;
                push_cmd.kind      = CMD_START;
                push_cmd.crc_after = (plen_c == '0);
                open_next          = (plen_c != '0);
                remain_next        = plen_c;
            end
            else if (open_reg && remain_reg != '0)
            begin
                push               = 1'b1;
                push_cmd.kind      = CMD_DATA;
                push_cmd.crc_after = (remain_reg == LEN_W'(1));
                remain_next        = remain_reg - LEN_W'(1);
                open_next          = (remain_reg != LEN_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/cfb_queue.sv */
// short command queue between front and back
// depends on cfb_pkg
`default_nettype none

module cfb_queue
    import cfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

/* rtl/cfb_back.sv */
// back end: steps through queued commands, runs the crc, drives the output beat
// depends on cfb_pkg and command_frame_builder_crc16_top_defines.svh
`default_nettype none
`include "command_frame_builder_crc16_top_defines.svh"

module cfb_back
    import cfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire cmd_t        head,
    input  wire q_status_t   q_status,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       frame_byte,
    output logic             run_end,
    output logic             frame_end
);

    logic [31:0]       dest_reg, src_reg;
    logic [15:0]       crc_reg, crc_next, crc_base;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] body_last;
    logic              out_valid_reg;
    logic [7:0]        frame_byte_reg;
    logic              run_end_reg, frame_end_reg;
    logic              advance, is_body, is_crc_lo, is_crc_hi, done;
    logic [7:0]        body_byte, emit_byte;

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign run_end    = run_end_reg;
    assign frame_end  = frame_end_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= DEST_RESET;
            src_reg  <= SRC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEST: dest_reg <= cfg_data;
                REG_SRC:  src_reg  <= cfg_data;
                default:  dest_reg <= dest_reg;
            endcase
        end
    end

    // position decode for the head command
    always_comb
    begin
        body_last = (head.kind == CMD_START) ? HDR_OBJ2 : DATA_POS;
        is_body   = (step_reg <= body_last);
        is_crc_lo = (step_reg == body_last + STEP_W'(1));
        is_crc_hi = (step_reg == body_last + STEP_W'(2));
        done      = ((step_reg == body_last) && !head.crc_after) || is_crc_hi;
        advance   = !q_status.empty && (!out_valid_reg || !out_stall);
        pop       = advance && done;
    end

    // header and payload byte select
    always_comb
    begin
        if (head.kind == CMD_DATA)
            body_byte = head.data;
        else
        begin
            unique case (step_reg)
                HDR_DEST0: body_byte = dest_reg[31:24];
                HDR_DEST1: body_byte = dest_reg[23:16];
                HDR_DEST2: body_byte = dest_reg[15:8];
                HDR_DEST3: body_byte = dest_reg[7:0];
                HDR_SRC0:  body_byte = src_reg[31:24];
                HDR_SRC1:  body_byte = src_reg[23:16];
                HDR_SRC2:  body_byte = src_reg[15:8];
                HDR_SRC3:  body_byte = src_reg[7:0];
                HDR_LENLO: body_byte = head.total[7:0];
                HDR_LENHI: body_byte = head.total[15:8];
                HDR_OP:    body_byte = head.op;
                HDR_OBJ0:  body_byte = head.obj[7:0];
                HDR_OBJ1:  body_byte = head.obj[15:8];
                HDR_OBJ2:  body_byte = head.obj[23:16];
                default:   body_byte = 8'h00;
            endcase
        end
    end

    // crc and output byte
    always_comb
    begin
        crc_base = ((head.kind == CMD_START) && (step_reg == HDR_DEST0)) ? CRC_INIT : crc_reg;
        crc_next = crc_reg;
        if (advance && is_body)
            crc_next = crc_update(crc_base, body_byte);
        priority if (is_crc_lo)
            emit_byte = crc_reg[7:0];
        else if (is_crc_hi)
            emit_byte = crc_reg[15:8];
        else
            emit_byte = body_byte;
        step_next = step_reg;
        if (advance)
            step_next = done ? '0 : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            step_reg <= step_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            frame_byte_reg <= emit_byte;
            run_end_reg    <= done;
            frame_end_reg  <= is_crc_hi;
        end
    end

    `CFB_ASSERT_IMPL(a_fend_has_run_end, clk, rst_n, out_valid_reg && frame_end_reg, run_end_reg)
    `CFB_ASSERT_IMPL(a_data_step_bound, clk, rst_n, advance && head.kind == CMD_DATA, step_reg <= STEP_W'(2))
    `CFB_ASSERT_NEXT(a_crc_hi_is_end, clk, rst_n, advance && is_crc_hi, out_valid_reg && frame_end_reg)

endmodule

`default_nettype wire

/* rtl/command_frame_builder_crc16_top.sv */
// top level of the command frame builder with crc-16 trailer
// depends on cfb_pkg, cfb_front, cfb_queue, cfb_back
//
// input channel: in_valid / in_stall carry one beat per item. action 0 opens a
// frame (operation, object_id, payload_length); action 1 carries payload_byte.
// a start beat yields 14 output bytes (addresses, length, operation, object),
// plus the two crc bytes when the payload length is zero. a data beat of an
// open frame yields one byte, plus the crc when it is the last one; data with
// no frame open yields nothing. run_end marks the last byte of each input
// beat, frame_end the high crc byte.
// output channel: out_valid / out_stall, one byte per cycle from a register
// while out_stall is low and a command is queued. an accepted beat is first
// written into the command queue, then its first byte is registered at the
// output. the back end sequencer sets the output rate; while it steps through
// the bytes of one beat, the 4-entry command queue keeps taking input.
// configuration: cfg_we, cfg_index, cfg_data write the destination (0) or
// source (1) address; the user must do so only while the block is idle, as
// the block does not enforce it. reset: frame closed, crc at all ones,
// addresses at their defaults, queue empty. when out_stall is high the output
// byte holds and the queue fills; in_stall rises when it is full.
`default_nettype none

module command_frame_builder_crc16_top
    import cfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [31:0]      cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             action,
    input  wire logic [7:0]       operation,
    input  wire logic [23:0]      object_id,
    input  wire logic [LEN_W-1:0] payload_length,
    input  wire logic [7:0]       payload_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            frame_byte,
    output logic                  run_end,
    output logic                  frame_end
);

    q_status_t q_status;
    logic      push, pop;
    cmd_t      push_cmd, head;

    cfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .operation      (operation),
        .object_id      (object_id),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .q_status       (q_status),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    cfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .run_end    (run_end),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire

/* test/frame_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// scoreboard for the command frame builder: predicts every frame byte per input beat
// depends on cfb_pkg for the command kind and register index codes
package frame_scoreboard_pkg;

    import cfb_pkg::*;

    localparam int unsigned PAYLOAD_CAP   = 1024;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_REFL_POLY = 16'hA001;
    localparam logic [15:0] HEADER_TAIL   = 16'd6;
    localparam logic [15:0] SHORTEST_LEN  = 16'd8;
    localparam int unsigned REPORT_LIMIT  = 10;

    // one expected output beat
    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       frame_end;
    } frame_byte_t;

    // crc-16/modbus, one byte, lsb first
    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_REFL_POLY) : (r >> 1);
        end
        return r;
    endfunction

    class frame_scoreboard;
        logic [31:0] dest_addr;
        logic [31:0] src_addr;
        logic [15:0] crc;
        int unsigned bytes_left;
        bit          frame_open;
        frame_byte_t owed_bytes[$];
        int unsigned errors;

        function new();
            dest_addr  = 32'h0100_0110;
            src_addr   = 32'h0000_0001;
            crc        = CRC_SEED;
            bytes_left = 0;
            frame_open = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] val);
            if (idx == REG_DEST)
                dest_addr = val;
            else
                src_addr = val;
        endfunction

        function void emit(logic [7:0] b, logic is_last_crc);
            frame_byte_t fb;
            fb.value     = b;
            fb.run_end   = 1'b0;
            fb.frame_end = is_last_crc;
            owed_bytes.push_back(fb);
        endfunction

        // byte that also runs through the crc
        function void emit_fed(logic [7:0] b);
            crc = crc16_step(crc, b);
            emit(b, 1'b0);
        endfunction

        function void close_frame();
            emit(crc[7:0], 1'b0);
            emit(crc[15:8], 1'b1);
            frame_open = 0;
            bytes_left = 0;
        endfunction

        // predict the bytes caused by one accepted input beat
        function void take_command(cmd_kind_t kind, logic [7:0] op, logic [23:0] obj,
                                   logic [10:0] plen, logic [7:0] pb);
            int unsigned before_n;
            int unsigned len;
            logic [15:0] total;
            frame_byte_t last_fb;
            before_n = owed_bytes.size();
            if (kind == CMD_START)
            begin
                // oversize length saturates; an open frame is simply abandoned
                len = (plen > PAYLOAD_CAP) ? PAYLOAD_CAP : plen;
                crc = CRC_SEED;
                frame_open = 1;
                bytes_left = len;
                for (int i = 3; i >= 0; i--)
                    emit_fed(dest_addr[8*i +: 8]);
                for (int i = 3; i >= 0; i--)
                    emit_fed(src_addr[8*i +: 8]);
                total = 16'(len) + HEADER_TAIL;
                if (total < SHORTEST_LEN)
                    total = SHORTEST_LEN;
                emit_fed(total[7:0]);
                emit_fed(total[15:8]);
                emit_fed(op);
                emit_fed(obj[7:0]);
                emit_fed(obj[15:8]);
                emit_fed(obj[23:16]);
                if (bytes_left == 0)
                    close_frame();
            end
            else if (frame_open && bytes_left != 0)
            begin
                emit_fed(pb);
                bytes_left--;
                if (bytes_left == 0)
                    close_frame();
            end
            // mark the last byte of this beat
            if (owed_bytes.size() > before_n)
            begin
                last_fb = owed_bytes.pop_back();
                last_fb.run_end = 1'b1;
                owed_bytes.push_back(last_fb);
            end
        endfunction

        function void check_byte(logic [7:0] fb, logic re, logic fe);
            frame_byte_t want;
            if (owed_bytes.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected frame byte %02h run_end %b frame_end %b", fb, re, fe);
            end
            else
            begin
                want = owed_bytes.pop_front();
                if (want.value !== fb || want.run_end !== re || want.frame_end !== fe)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("frame byte mismatch: expected %02h/%b/%b got %02h/%b/%b",
                                 want.value, want.run_end, want.frame_end, fb, re, fe);
                end
            end
        endfunction
    endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 100ps
// testbench top for command_frame_builder_crc16_top: directed and random command beats
// depends on cfb_pkg, frame_scoreboard_pkg and the frame builder rtl
module tb;

    import cfb_pkg::*;
    import frame_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_BEATS  = 100;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_we         = 1'b0;
    logic        cfg_index      = REG_DEST;
    logic [31:0] cfg_data       = 32'h0;
    logic        in_valid       = 1'b0;
    logic        action         = ACT_START;
    logic [7:0]  operation      = 8'h0;
    logic [23:0] object_id      = 24'h0;
    logic [10:0] payload_length = 11'h0;
    logic [7:0]  payload_byte   = 8'h0;
    logic        out_stall      = 1'b0;
    wire logic       in_stall;
    wire logic       out_valid;
    wire logic [7:0] frame_byte;
    wire logic       run_end;
    wire logic       frame_end;

    frame_scoreboard sb;
    int unsigned tx_idle_pct = 24;
    int unsigned rx_idle_pct = 24;
    int unsigned hold_req    = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;
    int unsigned cycle_count = 0;
    int unsigned phase;

    command_frame_builder_crc16_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .operation      (operation),
        .object_id      (object_id),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .run_end        (run_end),
        .frame_end      (frame_end)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // output beats go to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_byte(frame_byte, run_end, frame_end);
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one beat from a falling edge and hold it until accepted
    task automatic send_beat(cmd_kind_t kind, logic [7:0] op, logic [23:0] obj,
                             logic [10:0] plen, logic [7:0] pb);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        action         = kind;
        operation      = op;
        object_id      = obj;
        payload_length = plen;
        payload_byte   = pb;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_command(kind, op, obj, plen, pb);
        @(negedge clk);
    endtask

    task automatic send_start(logic [10:0] plen);
        send_beat(CMD_START, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)),
                  plen, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_data();
        send_beat(CMD_DATA, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)),
                  11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
    endtask

    // wait for every owed byte, then let dropped beats clear the block
    task automatic drain();
        in_valid = 1'b0;
        while (sb.owed_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // mostly well-formed frames with random content, some truncated or overrun
    task automatic run_traffic(int unsigned beats);
        int unsigned sent;
        int unsigned pick;
        int unsigned plen;
        int unsigned full;
        int unsigned count;
        sent = 0;
        while (sent < beats)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_data();
                sent++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    plen = $urandom_range(0, 8);
                else if (pick < 90)
                    plen = $urandom_range(9, 40);
                else if (pick < 97)
                    plen = $urandom_range(41, 150);
                else
                    plen = $urandom_range(151, 2047);
                send_start(11'(plen));
                sent++;
                full = (plen > PAYLOAD_CAP) ? PAYLOAD_CAP : plen;
                pick = $urandom_range(0, 99);
                if (plen > 150)
                    count = $urandom_range(0, 12);
                else if (pick < 80)
                    count = full;
                else if (pick < 90)
                    count = (full == 0) ? 0 : $urandom_range(0, full - 1);
                else
                    count = full + $urandom_range(1, 3);
                repeat (count)
                begin
                    send_data();
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed beats with the reset addresses
        send_beat(CMD_DATA, 8'h00, 24'h000000, 11'd0, 8'hFF);       // data with no frame
        send_beat(CMD_START, 8'h00, 24'h000000, 11'd0, 8'h00);      // empty frame, crc at once
        send_beat(CMD_START, 8'hFF, 24'hFFFFFF, 11'd1, 8'hFF);      // length raised to 8
        send_beat(CMD_DATA, 8'hFF, 24'hFFFFFF, 11'h7FF, 8'h00);
        send_beat(CMD_START, 8'hA5, 24'h123456, 11'd2, 8'h5A);
        send_beat(CMD_DATA, 8'h5A, 24'hABCDEF, 11'd0, 8'hFF);
        send_beat(CMD_DATA, 8'h00, 24'h000000, 11'd0, 8'h5A);
        send_beat(CMD_DATA, 8'h11, 24'h222222, 11'd3, 8'h33);       // dropped after close
        send_beat(CMD_START, 8'h3C, 24'h00FF00, 11'd3, 8'h00);
        send_beat(CMD_DATA, 8'hC3, 24'hFF00FF, 11'd5, 8'h80);
        send_beat(CMD_START, 8'h81, 24'h800001, 11'h7FF, 8'h01);    // abandon, oversize length
        send_beat(CMD_DATA, 8'h00, 24'h000000, 11'd0, 8'h01);
        send_beat(CMD_DATA, 8'h00, 24'h000000, 11'd0, 8'hFE);
        send_beat(CMD_START, 8'h7E, 24'h7FFFFF, 11'd1024, 8'h00);   // abandon, exact cap
        send_beat(CMD_DATA, 8'h00, 24'h000000, 11'd0, 8'h7F);
        send_beat(CMD_START, 8'h01, 24'h000001, 11'd1025, 8'h00);   // abandon, cap plus one
        send_beat(CMD_START, 8'h02, 24'h010203, 11'd0, 8'h00);      // abandon into empty frame
        send_beat(CMD_START, 8'h10, 24'h000100, 11'd4, 8'h00);
        repeat (4) send_data();

        // random phases, each under its own address setting
        for (phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(REG_DEST, 32'h0000_0000);
                    write_reg(REG_SRC, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_reg(REG_DEST, 32'hFFFF_FFFF);
                    write_reg(REG_SRC, 32'h0000_0000);
                    // no idling, and a long receiver hold-off to fill the block
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_req    = hold_req + 1;
                end
                default:
                begin
                    tx_idle_pct = 24;
                    rx_idle_pct = 24;
                    write_reg(REG_DEST, $urandom);
                    write_reg(REG_SRC, $urandom);
                end
            endcase
            run_traffic(PHASE_BEATS);
        end

        drain();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* command_frame_builder_crc16_top.f */
+incdir+rtl
rtl/cfb_pkg.sv
rtl/cfb_front.sv
rtl/cfb_queue.sv
rtl/cfb_back.sv
rtl/command_frame_builder_crc16_top.sv
test/frame_scoreboard_pkg.sv
test/tb.sv
